// ===== rtl/ppjs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppjs_pkg: shared types and constants of the priority job scheduler
// Slot count, field widths, request and status codes, and the command
// bundle that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package ppjs_pkg;

  // Table size and derived index width
  localparam int JOB_SLOTS = 16;
  localparam int SLOT_W    = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;

  // Field widths
  localparam int ID_W   = 16;
  localparam int PRIO_W = 8;
  localparam int WORK_W = 16;
  localparam int STAT_W = 2;

  // Request codes
  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_IDLE = 2'd1;
  localparam logic [STAT_W-1:0] ST_DUP  = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic              load;    // capture the accepted item
    logic              scan;    // examine one table slot
    logic              first;   // this scan step is the first slot
    logic              commit;  // update the table and load the result
    logic [SLOT_W-1:0] idx;     // slot under examination
  } ppjs_cmd_t;

endpackage

// ===== rtl/ppjs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppjs_if: request and result channels of the priority job scheduler
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ppjs_req_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [ppjs_pkg::ID_W-1:0]   job_id;
  logic [ppjs_pkg::PRIO_W-1:0] job_priority;
  logic [ppjs_pkg::WORK_W-1:0] work_units;

  modport source (output valid, req_type, job_id, job_priority, work_units,
                  input ready);
  modport sink   (input valid, req_type, job_id, job_priority, work_units,
                  output ready);
endinterface

interface ppjs_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [ppjs_pkg::ID_W-1:0]   run_id;
  logic [ppjs_pkg::STAT_W-1:0] status;
  logic                      job_done;

  modport source (output valid, run_id, status, job_done, input ready);
  modport sink   (input valid, run_id, status, job_done, output ready);
endinterface

// ===== rtl/ppjs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppjs_ctrl: sequencer of the priority job scheduler
// Accepts one item, steps the slot index over the table, then commits the
// update and loads the result register once it is free.
// ----------------------------------------------------------------------------
module ppjs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ppjs_pkg::ppjs_cmd_t  cmd
);
  import ppjs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(JOB_SLOTS - 1);

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] idx_next;
  logic              accept;
  logic              commit;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign commit   = (state == S_DONE) && (!out_valid || out_ready);

  // Next state and slot index
  always_comb begin
    state_next = state;
    idx_next   = idx;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_SCAN;
          idx_next   = '0;
        end
      end
      S_SCAN: begin
        idx_next = idx + SLOT_W'(1);
        if (idx == LAST_IDX) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, index and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Drive datapath commands
  always_comb begin
    cmd.load   = accept;
    cmd.scan   = (state == S_SCAN);
    cmd.first  = (idx == '0);
    cmd.commit = commit;
    cmd.idx    = idx;
  end

endmodule

// ===== rtl/ppjs_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppjs_dp: job table and scan datapath of the priority job scheduler
// Holds the slot table, accumulates the duplicate, free-slot and best-job
// search one slot per scan step, and forms the result on commit.
// ----------------------------------------------------------------------------
module ppjs_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  ppjs_pkg::ppjs_cmd_t          cmd,
  input  logic                         in_req_type,
  input  logic [ppjs_pkg::ID_W-1:0]    in_job_id,
  input  logic [ppjs_pkg::PRIO_W-1:0]  in_job_priority,
  input  logic [ppjs_pkg::WORK_W-1:0]  in_work_units,
  output logic [ppjs_pkg::ID_W-1:0]    run_id,
  output logic [ppjs_pkg::STAT_W-1:0]  status,
  output logic                         job_done
);
  import ppjs_pkg::*;

  // Job table
  logic [JOB_SLOTS-1:0] slot_valid;
  logic [ID_W-1:0]      slot_id        [JOB_SLOTS];
  logic [PRIO_W-1:0]    slot_priority  [JOB_SLOTS];
  logic [WORK_W-1:0]    slot_remaining [JOB_SLOTS];

  // Captured item
  logic              req_type;
  logic [ID_W-1:0]   req_id;
  logic [PRIO_W-1:0] req_prio;
  logic [WORK_W-1:0] req_work;

  // Search state
  logic              dup;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic              best_found;
  logic [SLOT_W-1:0] best_idx;
  logic [PRIO_W-1:0] best_prio;
  logic [ID_W-1:0]   best_id;
  logic [WORK_W-1:0] best_rem;

  logic              dup_next;
  logic              free_found_next;
  logic [SLOT_W-1:0] free_idx_next;
  logic              best_found_next;
  logic [SLOT_W-1:0] best_idx_next;
  logic [PRIO_W-1:0] best_prio_next;
  logic [ID_W-1:0]   best_id_next;
  logic [WORK_W-1:0] best_rem_next;

  logic              cur_valid;
  logic [PRIO_W-1:0] cur_prio;

  logic              store_job;
  logic              finish_job;
  logic              dec_job;

  assign cur_valid = slot_valid[cmd.idx];
  assign cur_prio  = slot_priority[cmd.idx];

  // Fold one slot into the search
  always_comb begin
    dup_next        = cmd.first ? 1'b0 : dup;
    free_found_next = cmd.first ? 1'b0 : free_found;
    free_idx_next   = free_idx;
    best_found_next = cmd.first ? 1'b0 : best_found;
    best_idx_next   = best_idx;
    best_prio_next  = best_prio;
    best_id_next    = best_id;
    best_rem_next   = best_rem;
    if (req_type == REQ_ARRIVAL) begin
      if (cur_valid && (cur_prio == req_prio)) begin
        dup_next = 1'b1;
      end
      if (!cur_valid && !free_found_next) begin
        free_found_next = 1'b1;
        free_idx_next   = cmd.idx;
      end
    end else begin
      if (cur_valid && (!best_found_next || (cur_prio > best_prio))) begin
        best_found_next = 1'b1;
        best_idx_next   = cmd.idx;
        best_prio_next  = cur_prio;
        best_id_next    = slot_id[cmd.idx];
        best_rem_next   = slot_remaining[cmd.idx];
      end
    end
  end

  // Capture item and advance search
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type <= in_req_type;
      req_id   <= in_job_id;
      req_prio <= in_job_priority;
      req_work <= in_work_units;
    end
    if (cmd.scan) begin
      dup        <= dup_next;
      free_found <= free_found_next;
      free_idx   <= free_idx_next;
      best_found <= best_found_next;
      best_idx   <= best_idx_next;
      best_prio  <= best_prio_next;
      best_id    <= best_id_next;
      best_rem   <= best_rem_next;
    end
  end

  // Table update decisions
  assign store_job  = cmd.commit && (req_type == REQ_ARRIVAL) && !dup && free_found
                      && (req_work != '0);
  assign finish_job = cmd.commit && (req_type == REQ_TICK) && best_found
                      && (best_rem <= WORK_W'(1));
  assign dec_job    = cmd.commit && (req_type == REQ_TICK) && best_found
                      && (best_rem > WORK_W'(1));

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (store_job) begin
      slot_valid[free_idx] <= 1'b1;
    end else if (finish_job) begin
      slot_valid[best_idx] <= 1'b0;
    end
  end

  // Slot payload
  always_ff @(posedge clk) begin
    if (store_job) begin
      slot_id[free_idx]        <= req_id;
      slot_priority[free_idx]  <= req_prio;
      slot_remaining[free_idx] <= req_work;
    end else if (dec_job) begin
      slot_remaining[best_idx] <= best_rem - WORK_W'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (req_type == REQ_ARRIVAL) begin
        run_id   <= '0;
        job_done <= 1'b0;
        if (dup) begin
          status <= ST_DUP;
        end else if (!free_found) begin
          status <= ST_FULL;
        end else begin
          status <= ST_OK;
        end
      end else if (!best_found) begin
        run_id   <= '0;
        status   <= ST_IDLE;
        job_done <= 1'b0;
      end else begin
        run_id   <= best_id;
        status   <= ST_OK;
        job_done <= (best_rem <= WORK_W'(1));
      end
    end
  end

endmodule

// ===== rtl/preemptive_priority_job_scheduler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_job_scheduler_top: preemptive priority job scheduler
// Arrivals store jobs in a slot table; ticks serve the highest-priority job
// one work unit and remove it when its work is used up.
// ----------------------------------------------------------------------------
//  channel  dir  fields                                        handshake
//  req      in   req_type, job_id, job_priority, work_units   valid/ready
//  rsp      out  run_id, status, job_done                      valid/ready
//
//  Each item is accepted, then scanned over every table slot (a single slot
//  is read per cycle), then committed.
//  A new item is taken once the previous one has committed; its result may
//  still wait in the output register meanwhile.
//  A stalled output holds commit of the next item until the register frees.
//  Reset (rst, synchronous) empties the table at once; no clearing pass.
// ----------------------------------------------------------------------------
module preemptive_priority_job_scheduler_top (
  input  logic       clk,
  input  logic       rst,
  ppjs_req_if.sink   req,
  ppjs_rsp_if.source rsp
);
  import ppjs_pkg::*;

  ppjs_cmd_t cmd;

  ppjs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  ppjs_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .in_req_type     (req.req_type),
    .in_job_id       (req.job_id),
    .in_job_priority (req.job_priority),
    .in_work_units   (req.work_units),
    .run_id          (rsp.run_id),
    .status          (rsp.status),
    .job_done        (rsp.job_done)
  );

  // Commit only into a free or draining result register
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!rsp.valid || rsp.ready))
    else $error("commit while result register still held");

  // No second item while one is in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("item accepted while scheduler busy");

  // Idle, duplicate and full results carry no job
  a_no_job_unless_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status != ST_OK)) |-> (rsp.run_id == '0 && !rsp.job_done))
    else $error("job reported with non-ok status");

  // An accepted item is followed by a scan that starts at slot zero
  a_load_then_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (cmd.scan && cmd.first))
    else $error("scan did not start at slot zero after accept");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the preemptive priority job scheduler
// Drives arrivals and ticks through the request channel, tracks a private
// copy of the job table to predict each result, and checks every result
// field by field. The sender runs in bursts, the receiver stalls in patterns,
// and once the receiver holds off long enough to back up the request side.
// ----------------------------------------------------------------------------
module tb;
  import ppjs_pkg::*;

  localparam int RANDOM_ITEMS = 927;
  localparam int HOLD_AT      = 400;   // accepted requests before the long hold-off
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 5000;  // cycles with no item moving on any channel
  localparam int DRAIN_CYCLES = 4 * (JOB_SLOTS + 2);

  typedef struct {
    logic [ID_W-1:0]   run_id;
    logic [STAT_W-1:0] status;
    logic              job_done;
  } sched_result_t;

  // Job table mirror and queue of results still due from the block
  class sched_scoreboard;
    bit                slot_valid[JOB_SLOTS];
    logic [ID_W-1:0]   slot_id[JOB_SLOTS];
    logic [PRIO_W-1:0] slot_prio[JOB_SLOTS];
    logic [WORK_W-1:0] slot_left[JOB_SLOTS];
    sched_result_t     due_results[$];
    int mismatches, served, finished, idle_ticks, dup_drops, full_drops, stored, checked;

    function void note_request(logic req_type, logic [ID_W-1:0] id,
                               logic [PRIO_W-1:0] prio, logic [WORK_W-1:0] work);
      sched_result_t exp;
      int free_slot;
      int best;
      bit dup;
      exp.run_id   = '0;
      exp.status   = ST_OK;
      exp.job_done = 1'b0;
      if (req_type == REQ_ARRIVAL) begin
        // Duplicate priority wins over a full table
        free_slot = -1;
        dup = 1'b0;
        for (int k = 0; k < JOB_SLOTS; k++) begin
          if (slot_valid[k]) begin
            if (slot_prio[k] == prio) dup = 1'b1;
          end else if (free_slot < 0) begin
            free_slot = k;
          end
        end
        if (dup) begin
          exp.status = ST_DUP;
          dup_drops++;
        end else if (free_slot < 0) begin
          exp.status = ST_FULL;
          full_drops++;
        end else if (work != '0) begin
          // A job with no work is acknowledged but never stored
          slot_valid[free_slot] = 1'b1;
          slot_id[free_slot]    = id;
          slot_prio[free_slot]  = prio;
          slot_left[free_slot]  = work;
          stored++;
        end
      end else begin
        // Serve the highest priority; the lowest slot wins a tie
        best = -1;
        for (int k = 0; k < JOB_SLOTS; k++) begin
          if (slot_valid[k] && (best < 0 || slot_prio[k] > slot_prio[best])) best = k;
        end
        if (best < 0) begin
          exp.status = ST_IDLE;
          idle_ticks++;
        end else begin
          exp.run_id = slot_id[best];
          served++;
          if (slot_left[best] <= 1) begin
            slot_left[best]  = '0;
            slot_valid[best] = 1'b0;
            exp.job_done     = 1'b1;
            finished++;
          end else begin
            slot_left[best] = slot_left[best] - 1'b1;
          end
        end
      end
      due_results.push_back(exp);
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t exp;
      if (due_results.size() == 0) begin
        $error("result with none due: run_id %0d status %0d job_done %0d",
               got.run_id, got.status, got.job_done);
        mismatches++;
        return;
      end
      exp = due_results.pop_front();
      checked++;
      if (got.run_id !== exp.run_id) begin
        $error("run_id: expected %0d, got %0d", exp.run_id, got.run_id);
        mismatches++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        mismatches++;
      end
      if (got.job_done !== exp.job_done) begin
        $error("job_done: expected %0d, got %0d", exp.job_done, got.job_done);
        mismatches++;
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  int   accepted_reqs = 0;
  bit   hold_start = 1'b0;

  sched_scoreboard sb = new();

  ppjs_req_if req_if ();
  ppjs_rsp_if rsp_if ();

  preemptive_priority_job_scheduler_top i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .rsp (rsp_if.source)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Offer one item and hold it until the block takes it
  task automatic send_item(logic req_type, logic [ID_W-1:0] id,
                           logic [PRIO_W-1:0] prio, logic [WORK_W-1:0] work);
    req_if.valid        <= 1'b1;
    req_if.req_type     <= req_type;
    req_if.job_id       <= id;
    req_if.job_priority <= prio;
    req_if.work_units   <= work;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
  endtask

  task automatic idle_gap(int cycles);
    req_if.valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Note accepted requests, check accepted results
  always @(posedge clk) begin : monitor
    sched_result_t got;
    if (!rst) begin
      if (req_if.valid && req_if.ready) begin
        sb.note_request(req_if.req_type, req_if.job_id, req_if.job_priority,
                        req_if.work_units);
        accepted_reqs++;
        if (accepted_reqs == HOLD_AT) hold_start = 1'b1;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got.run_id   = rsp_if.run_id;
        got.status   = rsp_if.status;
        got.job_done = rsp_if.job_done;
        sb.check_result(got);
      end
    end
  end

  // Receiver: rotating stall patterns, one long hold-off
  initial begin : receiver
    logic [7:0] ready_pattern;
    int         pat_pos;
    int         pat_left;
    bit         hold_used;
    rsp_if.ready  = 1'b0;
    ready_pattern = 8'hFF;
    pat_pos       = 0;
    pat_left      = 0;
    hold_used     = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_start && !hold_used) begin
        hold_used = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        if (pat_left == 0) begin
          pat_left      = $urandom_range(32, 128);
          ready_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
          if (ready_pattern == 8'h00) ready_pattern = 8'h01;
        end
        rsp_if.ready <= ready_pattern[pat_pos];
        pat_pos  = (pat_pos + 1) % 8;
        pat_left--;
      end
    end
  end

  // End the run if nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    int               burst_left;
    logic             rtype;
    logic [PRIO_W-1:0] prio;
    logic [WORK_W-1:0] work;
    int               pick;

    rst                 = 1'b1;
    req_if.valid        = 1'b0;
    req_if.req_type     = REQ_ARRIVAL;
    req_if.job_id       = '0;
    req_if.job_priority = '0;
    req_if.work_units   = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Directed: idle tick, zero-work arrival, fill the table with extremes
    send_item(REQ_TICK, 16'($urandom), 8'($urandom), 16'($urandom));
    send_item(REQ_ARRIVAL, 16'h1234, 8'd100, 16'd0);
    send_item(REQ_ARRIVAL, 16'h0000, 8'd255, 16'd1);
    send_item(REQ_ARRIVAL, 16'hFFFF, 8'd0, 16'hFFFF);
    for (int i = 2; i < JOB_SLOTS; i++)
      send_item(REQ_ARRIVAL, 16'($urandom), 8'(16 * i), 16'($urandom_range(1, 3)));
    // Full table, then a duplicate priority that takes precedence over fullness
    send_item(REQ_ARRIVAL, 16'h5A5A, 8'd100, 16'd2);
    send_item(REQ_ARRIVAL, 16'hA5A5, 8'd255, 16'd2);
    // Finish the top job, reuse its slot, serve the next one
    send_item(REQ_TICK, 16'($urandom), 8'($urandom), 16'($urandom));
    send_item(REQ_ARRIVAL, 16'h5A5A, 8'd100, 16'd2);
    send_item(REQ_TICK, 16'($urandom), 8'($urandom), 16'($urandom));

    // Random: ticks slightly outnumber arrivals so the table keeps turning over
    burst_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 9) > 2) idle_gap($urandom_range(1, 12));
      end
      burst_left--;
      rtype = ($urandom_range(0, 99) < 55) ? REQ_TICK : REQ_ARRIVAL;
      prio  = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 31)) : 8'($urandom);
      pick  = $urandom_range(0, 99);
      if (pick < 5) begin
        work = '0;
      end else if (pick < 8) begin
        // Long jobs stay low so they do not starve the rest
        work = 16'($urandom);
        prio = 8'($urandom_range(0, 7));
      end else begin
        work = 16'($urandom_range(1, 6));
      end
      send_item(rtype, 16'($urandom), prio, work);
    end
    req_if.valid <= 1'b0;

    // Drain and watch for stray results
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results from %0d requests: %0d jobs stored, %0d served ticks,",
             sb.checked, accepted_reqs, sb.stored, sb.served);
    $display("%0d jobs finished, %0d idle ticks, %0d duplicate drops, %0d full-table drops",
             sb.finished, sb.idle_ticks, sb.dup_drops, sb.full_drops);
    if (sb.mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
